>>> design/nnsagu_pkg.sv
`timescale 1ns / 1ps

package nnsagu_pkg;

	localparam int ADDR_WIDTH_DEF = 32;
	localparam int BUS_ADDR_W     = 32;
	localparam int DIM_W          = 16;
	localparam int WORD_W         = 32;
	localparam int FRAC_BITS      = 10;
	localparam logic [WORD_W-1:0] PER_MILLE = 32'd1000;
	localparam logic [WORD_W-1:0] ROUND_UP  = 32'h3FF;
	// ceiling of 2^38 / 1000, exact floor division for any 32-bit dividend
	localparam int RECIP_SHIFT = 38;
	localparam logic [WORD_W-1:0] RECIP_PER_MILLE =
		WORD_W'(((64'd1 << RECIP_SHIFT) + 64'(PER_MILLE) - 64'd1) / 64'(PER_MILLE));

	typedef enum logic {
		OP_START   = 1'b0,
		OP_ADVANCE = 1'b1
	} op_t;

	typedef struct packed {
		op_t                   operation;
		logic [BUS_ADDR_W-1:0] src_base;
		logic [BUS_ADDR_W-1:0] dst_base;
		logic [DIM_W-1:0]      source_width;
		logic [DIM_W-1:0]      source_height;
		logic [DIM_W-1:0]      horiz_scale;
		logic [DIM_W-1:0]      vert_scale;
		logic [DIM_W-1:0]      rect_left;
		logic [DIM_W-1:0]      rect_top;
		logic [DIM_W-1:0]      rect_cols;
		logic [DIM_W-1:0]      rect_rows;
	} req_item_t;

	typedef struct packed {
		logic [BUS_ADDR_W-1:0] read_addr;
		logic [BUS_ADDR_W-1:0] write_addr;
		logic                  last_pixel;
	} rsp_item_t;

	typedef enum logic [1:0] {
		DSEL_COLS  = 2'd0,
		DSEL_ROWS  = 2'd1,
		DSEL_CSTEP = 2'd2,
		DSEL_RSTEP = 2'd3
	} div_sel_t;

	typedef struct packed {
		logic     latch_req;
		logic     calc_mul;
		logic     calc_org;
		logic     div_go;
		logic     div_take;
		div_sel_t div_sel;
		logic     commit;
		logic     adv_mul;
		logic     adv_addr;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic job_active;
		logic div_done;
		logic dims_zero;
	} dp_stat_t;

endpackage

>>> design/nnsagu_req_if.sv
`timescale 1ns / 1ps

interface nnsagu_req_if import nnsagu_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/nnsagu_rsp_if.sv
`timescale 1ns / 1ps

interface nnsagu_rsp_if import nnsagu_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/nnsagu_div.sv
`timescale 1ns / 1ps

module nnsagu_div import nnsagu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [WORD_W-1:0] num,
	input  logic [WORD_W-1:0] den,
	output logic              done,
	output logic [WORD_W-1:0] quo
);

	localparam int CNT_W = $clog2(WORD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] den_q;
	logic              zero_q;

	logic [WORD_W:0]   rem_sh;
	logic [WORD_W:0]   diff;
	logic              fits;

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[WORD_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign fits   = ~diff[WORD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= '0;
			quo_q  <= num;
			den_q  <= den;
			zero_q <= (den == '0);
		end else if (busy_q) begin
			rem_q <= fits ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = zero_q ? '0 : quo_q;

endmodule

>>> design/nnsagu_ctrl.sv
`timescale 1ns / 1ps

module nnsagu_ctrl import nnsagu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  op_t      req_op,
	output logic     req_ready,
	input  logic     rsp_ready,
	output logic     rsp_valid,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [11:0] {
		S_IDLE     = 12'b000000000001,
		S_MUL      = 12'b000000000010,
		S_ORG      = 12'b000000000100,
		S_DCOLS    = 12'b000000001000,
		S_DROWS    = 12'b000000010000,
		S_CHECK    = 12'b000000100000,
		S_DCSTEP   = 12'b000001000000,
		S_DRSTEP   = 12'b000010000000,
		S_COMMIT   = 12'b000100000000,
		S_ADV_MUL  = 12'b001000000000,
		S_ADV_ADDR = 12'b010000000000,
		S_ADV_OUT  = 12'b100000000000
	} state_t;

	state_t state_q, state_d;
	logic   div_run_q, div_run_d;
	logic   rsp_valid_q;
	logic   accept;
	logic   out_free;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		div_run_d = div_run_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_op == OP_START) begin
						// a start during a running job is dropped
						if (!stat.job_active) begin
							cmd.latch_req = 1'b1;
							state_d       = S_MUL;
						end
					end else if (stat.job_active) begin
						state_d = S_ADV_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.calc_mul = 1'b1;
				state_d      = S_ORG;
			end
			S_ORG: begin
				cmd.calc_org = 1'b1;
				state_d      = S_DCOLS;
			end
			S_DCOLS: begin
				// destination size by reciprocal multiply
				cmd.div_sel  = DSEL_COLS;
				cmd.div_take = 1'b1;
				state_d      = S_DROWS;
			end
			S_DROWS: begin
				cmd.div_sel  = DSEL_ROWS;
				cmd.div_take = 1'b1;
				state_d      = S_CHECK;
			end
			S_DCSTEP, S_DRSTEP: begin
				cmd.div_sel = (state_q == S_DCSTEP) ? DSEL_CSTEP : DSEL_RSTEP;
				if (!div_run_q) begin
					cmd.div_go = 1'b1;
					div_run_d  = 1'b1;
				end else if (stat.div_done) begin
					cmd.div_take = 1'b1;
					div_run_d    = 1'b0;
					state_d      = (state_q == S_DCSTEP) ? S_DRSTEP : S_COMMIT;
				end
			end
			S_CHECK: begin
				// empty destination: the job never starts
				state_d = stat.dims_zero ? S_IDLE : S_DCSTEP;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_IDLE;
			end
			S_ADV_MUL: begin
				cmd.adv_mul = 1'b1;
				state_d     = S_ADV_ADDR;
			end
			S_ADV_ADDR: begin
				cmd.adv_addr = 1'b1;
				state_d      = S_ADV_OUT;
			end
			S_ADV_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d   = S_IDLE;
				div_run_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_run_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			div_run_q <= div_run_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

>>> design/nnsagu_dp.sv
`timescale 1ns / 1ps

module nnsagu_dp import nnsagu_pkg::*; #(
	parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t req_data,
	output rsp_item_t rsp_data,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat
);

	localparam int PROD_W = 2 * WORD_W;

	// start transaction fields
	logic [ADDR_WIDTH-1:0] sb_q, db_q;
	logic [DIM_W-1:0]      sw_q, sh_q, hs_q, vs_q, rl_q, rt_q, rc_q, rr_q;

	logic [WORD_W-1:0]     prod_w_q, prod_h_q, org_prod_q;

	// job state
	logic                  job_active_q;
	logic [WORD_W-1:0]     col_cnt_q, row_cnt_q;
	logic [WORD_W-1:0]     out_cols_q, out_rows_q;
	logic [WORD_W-1:0]     col_step_q, row_step_q;
	logic [ADDR_WIDTH-1:0] origin_q, next_write_q;
	logic [DIM_W-1:0]      stride_q;

	// advance pipeline
	logic [WORD_W-1:0]     prod_r_s1, prod_c_s1;
	logic [ADDR_WIDTH-1:0] wr_s1, wr_s2;
	logic                  last_s1, last_s2;
	logic [WORD_W-1:0]     line_s2;
	logic [ADDR_WIDTH-1:0] sx2_s2;

	// output register
	logic [ADDR_WIDTH-1:0] rd_q, wr_q;
	logic                  last_q;

	logic [WORD_W-1:0]     div_num, div_den, div_quo;
	logic                  div_done;
	logic [PROD_W-1:0]     recip_prod;
	logic [WORD_W-1:0]     recip_quo;
	logic [WORD_W-1:0]     org_sum;
	logic [WORD_W-1:0]     col_next, row_next;
	logic [WORD_W-1:0]     sy, sx;

	always_comb begin
		if (cmd.div_sel == DSEL_CSTEP) begin
			div_num = (WORD_W'(rc_q) - WORD_W'(2)) << FRAC_BITS;
			div_den = out_cols_q - WORD_W'(1);
		end else begin
			div_num = (WORD_W'(rr_q) - WORD_W'(2)) << FRAC_BITS;
			div_den = out_rows_q - WORD_W'(1);
		end
	end

	nnsagu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// divide by 1000 as a multiply by its reciprocal
	assign recip_prod = PROD_W'((cmd.div_sel == DSEL_ROWS) ? prod_h_q : prod_w_q)
		* PROD_W'(RECIP_PER_MILLE);
	assign recip_quo  = WORD_W'(recip_prod >> RECIP_SHIFT);

	assign org_sum  = org_prod_q + WORD_W'(rl_q);
	assign col_next = col_cnt_q + WORD_W'(1);
	assign row_next = row_cnt_q + WORD_W'(1);
	// source coordinates round upward
	assign sy       = (prod_r_s1 + ROUND_UP) >> FRAC_BITS;
	assign sx       = (prod_c_s1 + ROUND_UP) >> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_active_q <= 1'b0;
		end else if (cmd.commit) begin
			job_active_q <= 1'b1;
		end else if (cmd.adv_mul && col_next >= out_cols_q && row_next >= out_rows_q) begin
			job_active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			sb_q <= req_data.src_base[ADDR_WIDTH-1:0];
			db_q <= req_data.dst_base[ADDR_WIDTH-1:0];
			sw_q <= req_data.source_width;
			sh_q <= req_data.source_height;
			hs_q <= req_data.horiz_scale;
			vs_q <= req_data.vert_scale;
			rl_q <= req_data.rect_left;
			rt_q <= req_data.rect_top;
			rc_q <= req_data.rect_cols;
			rr_q <= req_data.rect_rows;
		end
		if (cmd.calc_mul) begin
			prod_w_q   <= WORD_W'(sw_q) * WORD_W'(hs_q);
			prod_h_q   <= WORD_W'(sh_q) * WORD_W'(vs_q);
			org_prod_q <= WORD_W'(rt_q) * WORD_W'(sw_q);
		end
		if (cmd.calc_org) begin
			origin_q <= sb_q + ADDR_WIDTH'(org_sum << 1);
		end
		if (cmd.div_take) begin
			case (cmd.div_sel)
				DSEL_COLS:  out_cols_q <= recip_quo;
				DSEL_ROWS:  out_rows_q <= recip_quo;
				DSEL_CSTEP: col_step_q <= div_quo;
				default:    row_step_q <= div_quo;
			endcase
		end
		if (cmd.commit) begin
			col_cnt_q    <= '0;
			row_cnt_q    <= '0;
			next_write_q <= db_q;
			stride_q     <= sw_q;
		end
		if (cmd.adv_mul) begin
			prod_r_s1    <= WORD_W'(row_cnt_q * row_step_q);
			prod_c_s1    <= WORD_W'(col_cnt_q * col_step_q);
			wr_s1        <= next_write_q;
			next_write_q <= next_write_q + ADDR_WIDTH'(2);
			last_s1      <= 1'b0;
			if (col_next >= out_cols_q) begin
				col_cnt_q <= '0;
				if (row_next >= out_rows_q) begin
					row_cnt_q <= '0;
					last_s1   <= 1'b1;
				end else begin
					row_cnt_q <= row_next;
				end
			end else begin
				col_cnt_q <= col_next;
			end
		end
		if (cmd.adv_addr) begin
			line_s2 <= WORD_W'(sy * WORD_W'(stride_q));
			sx2_s2  <= ADDR_WIDTH'(sx << 1);
			wr_s2   <= wr_s1;
			last_s2 <= last_s1;
		end
		if (cmd.load_out) begin
			rd_q   <= origin_q + ADDR_WIDTH'(line_s2 << 1) + sx2_s2;
			wr_q   <= wr_s2;
			last_q <= last_s2;
		end
	end

	assign stat.job_active = job_active_q;
	assign stat.div_done   = div_done;
	assign stat.dims_zero  = (out_cols_q == '0) || (out_rows_q == '0);

	assign rsp_data.read_addr  = BUS_ADDR_W'(rd_q);
	assign rsp_data.write_addr = BUS_ADDR_W'(wr_q);
	assign rsp_data.last_pixel = last_q;

endmodule

>>> design/nearest_neighbor_scaler_agu_top.sv
`timescale 1ns / 1ps

// Nearest-neighbor scaling address generator for 16-bit pixels. A start
// transaction (operation 0) sets up a job: destination size from the source
// size and per-mille scales, 10-bit fixed-point step factors and the source
// rectangle origin; it is dropped while a job runs, and a job with an empty
// destination never starts. Each advance transaction (operation 1) of a running
// job returns one read address, one write address and a last-pixel flag, in
// raster order; advances with no job give nothing. A start that begins a job
// holds the input until the job commits; the shared radix-2 divider runs the two
// 32-step step-factor divisions, and the destination size comes from a
// reciprocal multiply. A start with an empty destination ends at the size check.
// An advance passes the two registered multiply stages of the address path and
// then the output register; no new input is taken until its result is loaded, so
// advances do not overlap. Input is taken while an earlier result
// still waits in the output register; an advance then waits for it to leave.
// Addresses wrap at ADDR_WIDTH bits and are zero-extended on the ports.
module nearest_neighbor_scaler_agu_top import nnsagu_pkg::*; #(
	parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	nnsagu_req_if.sink   req,
	nnsagu_rsp_if.source rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	nnsagu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.data.operation),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd),
		.stat      (stat)
	);

	nnsagu_dp #(
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.rsp_data (rsp.data),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
